[design/tcw_pkg.sv]
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	// Field widths
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 11;
	localparam int DATA_W = ATTR_W + CHAR_W;

	// Cursor state widths
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);

	// Character and attribute codes
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CHAR_RETURN  = CHAR_W'(13);
	localparam logic [CHAR_W-1:0] CHAR_NONE    = '0;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = ATTR_W'(7);

	typedef enum logic [OP_W-1:0] {
		OP_PUT,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_SCROLL_COPY,
		ST_SCROLL_BLANK,
		ST_FINISH
	} state_t;

	// Screen memory access, one write and one read per cycle
	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [CELL_W-1:0] raddr;
	} ram_req_t;

endpackage

[design/tcw_if.sv]
interface tcw_cmd_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [CHAR_W-1:0] char_code;
	logic [CELL_W-1:0] cell_index;

	modport source (output valid, operation, char_code, cell_index, input ready);
	modport sink (input valid, operation, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cursor_offset;
	logic [DATA_W-1:0] cell_value;

	modport source (output valid, cursor_offset, cell_value, input ready);
	modport sink (input valid, cursor_offset, cell_value, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[design/tcw_screen_ram.sv]
module tcw_screen_ram import tcw_pkg::*; (
	input  logic              clk,
	input  ram_req_t          req,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [CELL_COUNT];
	logic [DATA_W-1:0] rdata_q;

	// Write one cell
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read one cell, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/tcw_sequencer.sv]
module tcw_sequencer import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tcw_cmd_if.sink           cmd,
	input  logic [ATTR_W-1:0] text_attribute,
	input  logic [DATA_W-1:0] ram_rdata,
	input  logic              res_free,
	output ram_req_t          ram_req,
	output logic              res_load,
	output logic [CELL_W-1:0] res_cursor,
	output logic [DATA_W-1:0] res_value
);

	localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0] LAST_COPY  = CELL_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [CELL_W-1:0] FIRST_BOT  = CELL_W'(CELL_COUNT - COLUMNS);
	localparam logic [CELL_W-1:0] ROW_STRIDE = CELL_W'(COLUMNS);

	state_t            state_q, state_d;
	logic [CELL_W-1:0] ptr_q, ptr_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [CELL_W-1:0] cursor_q, cursor_d;
	logic [DATA_W-1:0] value_q, value_d;
	logic              wr_pend_s1, wr_pend_d;
	logic [CELL_W-1:0] wr_addr_s1, wr_addr_d;

	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic [COL_W-1:0]  put_col;
	logic [ROW_W:0]    put_row;
	logic [ROW_W-1:0]  put_row_fit;
	logic [DATA_W-1:0] blank;
	op_t               op;

	assign op      = op_t'(cmd.operation);
	assign blank   = {text_attribute, CHAR_NONE};
	assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

	// Work out the column and row after a put
	always_comb begin
		put_col = col_q;
		put_row = {1'b0, row_q};
		if (cmd.char_code == CHAR_NEWLINE) begin
			put_row = row_inc;
			put_col = '0;
		end else if (cmd.char_code == CHAR_RETURN) begin
			put_row = row_inc;
		end else if (col_inc >= (COL_W+1)'(COLUMNS)) begin
			put_row = row_inc;
			put_col = '0;
		end else begin
			put_col = col_inc[COL_W-1:0];
		end
		if (put_row >= (ROW_W+1)'(ROWS)) begin
			put_row_fit = ROW_W'(ROWS - 1);
		end else begin
			put_row_fit = put_row[ROW_W-1:0];
		end
	end

	// Hold state, advance on next-state values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ptr_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			cursor_q   <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			ptr_q      <= ptr_d;
			col_q      <= col_d;
			row_q      <= row_d;
			cursor_q   <= cursor_d;
			wr_pend_s1 <= wr_pend_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		value_q    <= value_d;
		wr_addr_s1 <= wr_addr_d;
	end

	// Sequence each item over the shared memory port and pointer
	always_comb begin
		state_d       = state_q;
		ptr_d         = ptr_q;
		col_d         = col_q;
		row_d         = row_q;
		cursor_d      = cursor_q;
		value_d       = value_q;
		wr_pend_d     = 1'b0;
		wr_addr_d     = wr_addr_s1;
		ram_req.we    = 1'b0;
		ram_req.waddr = ptr_q;
		ram_req.wdata = blank;
		ram_req.raddr = cmd.cell_index;
		cmd.ready     = 1'b0;
		res_load      = 1'b0;

		case (state_q)
			ST_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = {ATTR_RESET, CHAR_NONE};
				if (ptr_q == LAST_CELL) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + CELL_W'(1);
				end
			end

			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					value_d = '0;
					ptr_d   = '0;
					case (op)
						OP_PUT: begin
							if (cmd.char_code != CHAR_NEWLINE
									&& cmd.char_code != CHAR_RETURN) begin
								ram_req.we    = 1'b1;
								ram_req.waddr = cursor_q;
								ram_req.wdata = {text_attribute, cmd.char_code};
							end
							col_d    = put_col;
							row_d    = put_row_fit;
							cursor_d = CELL_W'(put_row_fit) * ROW_STRIDE + CELL_W'(put_col);
							if (put_row >= (ROW_W+1)'(ROWS)) begin
								state_d = ST_SCROLL_COPY;
							end else begin
								state_d = ST_FINISH;
							end
						end
						OP_BACKSPACE: begin
							if (col_q != '0) begin
								col_d         = col_q - COL_W'(1);
								cursor_d      = cursor_q - CELL_W'(1);
								ram_req.we    = 1'b1;
								ram_req.waddr = cursor_q - CELL_W'(1);
							end
							state_d = ST_FINISH;
						end
						OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						OP_READ: begin
							if (cmd.cell_index < CELL_W'(CELL_COUNT)) begin
								state_d = ST_READ;
							end else begin
								state_d = ST_FINISH;
							end
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end

			ST_CLEAR: begin
				ram_req.we = 1'b1;
				if (ptr_q == LAST_CELL) begin
					state_d = ST_FINISH;
				end else begin
					ptr_d = ptr_q + CELL_W'(1);
				end
			end

			ST_READ: begin
				value_d = ram_rdata;
				state_d = ST_FINISH;
			end

			// Read one row down, write the cell read last cycle
			ST_SCROLL_COPY: begin
				ram_req.raddr = ptr_q + ROW_STRIDE;
				wr_pend_d     = 1'b1;
				wr_addr_d     = ptr_q;
				if (wr_pend_s1) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = wr_addr_s1;
					ram_req.wdata = ram_rdata;
				end
				if (ptr_q == LAST_COPY) begin
					ptr_d   = FIRST_BOT;
					state_d = ST_SCROLL_BLANK;
				end else begin
					ptr_d = ptr_q + CELL_W'(1);
				end
			end

			// Drain the last copy, then blank the bottom row
			ST_SCROLL_BLANK: begin
				ram_req.we = 1'b1;
				if (wr_pend_s1) begin
					ram_req.waddr = wr_addr_s1;
					ram_req.wdata = ram_rdata;
				end else if (ptr_q == LAST_CELL) begin
					state_d = ST_FINISH;
				end else begin
					ptr_d = ptr_q + CELL_W'(1);
				end
			end

			ST_FINISH: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_cursor = cursor_q;
	assign res_value  = value_q;

endmodule

[design/text_console_writer_top.sv]
// Channel | Dir | Payload                      | Handshake
// cmd     | in  | operation, char_code, cell_index | valid/ready
// rsp     | out | cursor_offset, cell_value    | valid/ready
// cfg     | in  | data (text_attribute)        | valid/ready, always ready
//
// A read of a cell in range waits on the registered memory read. A put
// that passes the last row scrolls, one cell per cycle through the single
// memory port. Clear blanks every cell. After reset a clearing pass writes
// every cell once (CELL_COUNT cells, 2000 here) while cmd is not ready;
// cfg is taken then. One result is held in an output register, so rsp
// stalls do not block the next item until its result is ready to load.
module text_console_writer_top import tcw_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	tcw_cmd_if.sink cmd,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink cfg
);

	logic [ATTR_W-1:0] attr_q;
	logic              res_valid_q;
	logic [CELL_W-1:0] res_cursor_q;
	logic [DATA_W-1:0] res_value_q;
	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;
	logic              res_free;
	logic              res_load;
	logic [CELL_W-1:0] res_cursor;
	logic [DATA_W-1:0] res_value;

	// Hold the attribute register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg.valid) begin
			attr_q <= cfg.data;
		end
	end

	tcw_sequencer u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.text_attribute (attr_q),
		.ram_rdata      (ram_rdata),
		.res_free       (res_free),
		.ram_req        (ram_req),
		.res_load       (res_load),
		.res_cursor     (res_cursor),
		.res_value      (res_value)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register: load a finished item, drop it when taken
	assign res_free = !res_valid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_cursor_q <= res_cursor;
			res_value_q  <= res_value;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.cursor_offset = res_cursor_q;
	assign rsp.cell_value    = res_value_q;

endmodule
